>>> design/uwsp_pkg.sv
// ----------------------------------------------------------------------------
// uwsp_pkg: shared constants for the unit-weight shortest path block
// Node count, field widths and item mode codes.
// ----------------------------------------------------------------------------
package uwsp_pkg;

    localparam int NODES   = 256;
    localparam int ID_W    = 8;
    localparam int DIST_W  = 9;
    localparam int LEN_W   = 9;
    localparam int CNT_W   = 3;
    localparam int NBR_MAX = 4;

    localparam logic [DIST_W-1:0] DIST_NONE = '1;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 24;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_SOLVE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

endpackage

>>> design/unit_weight_shortest_path.sv
// ----------------------------------------------------------------------------
// unit_weight_shortest_path: breadth-first path search over a loaded graph
// Rows load as they are accepted and path reads answer from the path store.
// A solve clears the distance memory, then pops each node from the queue
// and does a neighbor read-modify-write for each of its valid neighbors,
// then traces the path back from the end node to the start node.
// One transaction is in the block at a time; the result register frees the
// input side as soon as it is taken. Synchronous active-low reset marks all
// nodes absent and clears the stored path length.
// ----------------------------------------------------------------------------
module unit_weight_shortest_path
    import uwsp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // mode[1:0], node_id[9:2], node_present[10], neighbor_count[13:11],
    // neighbor_a[21:14], neighbor_b[29:22], neighbor_c[37:30],
    // neighbor_d[45:38], start_node[53:46], end_node[61:54],
    // path_index[69:62], zero fill [71:70]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // found[0], path_length[9:1], path_node[17:10], index_valid[18],
    // zero fill [23:19]
    output logic [M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDPATH,
        ST_CLEAR,
        ST_INIT,
        ST_POP,
        ST_FETCH,
        ST_NB_RD,
        ST_NB_WR,
        ST_TRACE,
        ST_TRACE_WAIT,
        ST_FINISH
    } state_t;

    // input field split
    logic [1:0]       in_mode;
    logic [ID_W-1:0]  in_node_id;
    logic             in_node_present;
    logic [CNT_W-1:0] in_neighbor_count;
    logic [4*ID_W-1:0] in_neighbors;
    logic [ID_W-1:0]  in_start_node;
    logic [ID_W-1:0]  in_end_node;
    logic [ID_W-1:0]  in_path_index;
    logic [CNT_W-1:0] cnt_sat;

    assign in_mode           = s_tdata[1:0];
    assign in_node_id        = s_tdata[9:2];
    assign in_node_present   = s_tdata[10];
    assign in_neighbor_count = s_tdata[13:11];
    assign in_neighbors      = s_tdata[45:14];
    assign in_start_node     = s_tdata[53:46];
    assign in_end_node       = s_tdata[61:54];
    assign in_path_index     = s_tdata[69:62];
    assign cnt_sat = (in_neighbor_count > CNT_W'(NBR_MAX)) ? CNT_W'(NBR_MAX)
                                                           : in_neighbor_count;

    // control and result registers
    state_t            state_reg;
    logic [ID_W:0]     clr_cnt_reg;
    logic [ID_W:0]     head_reg, tail_reg;
    logic [ID_W-1:0]   start_reg, end_reg;
    logic [ID_W-1:0]   u_reg, cur_reg, kidx_reg;
    logic [DIST_W-1:0] d_reg;
    logic [1:0]        k_reg;
    logic [LEN_W-1:0]  stored_len_reg, len_reg;
    logic              ivalid_reg, found_reg;
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic out_free;
    logic s_fire;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // node present flags: flip-flops so reset clears every node at once
    logic [NODES-1:0] present_reg;

    // memories: adjacency rows (count + 4 ids), distance/predecessor,
    // BFS queue (distance + id), path store
    localparam int ADJ_W = CNT_W + 4*ID_W;
    localparam int DP_W  = DIST_W + ID_W;
    localparam int Q_W   = DIST_W + ID_W;

    logic [ADJ_W-1:0] adj_mem [NODES];
    logic [DP_W-1:0]  dp_mem  [NODES];
    logic [Q_W-1:0]   q_mem   [NODES];
    logic [ID_W-1:0]  pth_mem [NODES];

    logic              adj_we;
    logic [ID_W-1:0]   adj_raddr;
    logic [ADJ_W-1:0]  adj_rdata_reg;
    logic              dp_we, dp_re;
    logic [ID_W-1:0]   dp_waddr, dp_raddr;
    logic [DP_W-1:0]   dp_wdata, dp_rdata_reg;
    logic              q_we, q_re;
    logic [ID_W-1:0]   q_waddr;
    logic [Q_W-1:0]    q_wdata, q_rdata_reg;
    logic              pth_we, pth_re;
    logic [ID_W-1:0]   pth_waddr;
    logic [ID_W-1:0]   pth_rdata_reg;

    // current neighbor out of the fetched row
    logic [ID_W-1:0]   nb_id;
    logic              nb_ok;
    logic [CNT_W-1:0]  row_cnt;
    logic [DIST_W-1:0] nb_dist, d_next;
    logic [ID_W-1:0]   nb_pred;
    logic              nb_new, nb_better;

    assign row_cnt   = adj_rdata_reg[ADJ_W-1 -: CNT_W];
    assign nb_id     = adj_rdata_reg[k_reg*ID_W +: ID_W];
    assign nb_ok     = ({1'b0, k_reg} < row_cnt) && present_reg[nb_id];
    assign nb_dist   = dp_rdata_reg[DP_W-1 -: DIST_W];
    assign nb_pred   = dp_rdata_reg[ID_W-1:0];
    assign d_next    = d_reg + DIST_W'(1);
    assign nb_new    = (nb_dist == DIST_NONE);
    assign nb_better = (nb_dist == d_next) && (nb_pred > u_reg);

    // memory port control
    always_comb begin
        adj_we    = 1'b0;
        adj_raddr = u_reg;
        dp_we     = 1'b0;
        dp_waddr  = clr_cnt_reg[ID_W-1:0];
        dp_wdata  = {DIST_NONE, {ID_W{1'b0}}};
        dp_re     = 1'b0;
        dp_raddr  = nb_id;
        q_we      = 1'b0;
        q_waddr   = tail_reg[ID_W-1:0];
        q_wdata   = {d_next, nb_id};
        q_re      = 1'b0;
        pth_we    = 1'b0;
        pth_waddr = kidx_reg;
        pth_re    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                adj_we = s_fire && (in_mode == MODE_LOAD);
                pth_re = s_fire && (in_mode == MODE_READ);
            end
            ST_CLEAR: begin
                dp_we = 1'b1;
            end
            ST_INIT: begin
                dp_we    = 1'b1;
                dp_waddr = start_reg;
                dp_wdata = {DIST_W'(0), start_reg};
                q_we     = 1'b1;
                q_waddr  = '0;
                q_wdata  = {DIST_W'(0), start_reg};
            end
            ST_POP: begin
                q_re = (head_reg != tail_reg);
            end
            ST_FETCH: begin
                adj_raddr = q_rdata_reg[ID_W-1:0];
            end
            ST_NB_RD: begin
                dp_re = nb_ok;
            end
            ST_NB_WR: begin
                dp_waddr = nb_id;
                dp_wdata = {d_next, u_reg};
                dp_we    = nb_new || nb_better;
                q_we     = nb_new;
            end
            ST_TRACE: begin
                pth_we   = 1'b1;
                dp_re    = (cur_reg != start_reg);
                dp_raddr = cur_reg;
            end
            ST_RDPATH, ST_TRACE_WAIT, ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adj_we) begin
            adj_mem[in_node_id] <= in_node_present ? {cnt_sat, in_neighbors} : '0;
        end
        adj_rdata_reg <= adj_mem[adj_raddr];
    end

    always_ff @(posedge aclk) begin
        if (dp_we) begin
            dp_mem[dp_waddr] <= dp_wdata;
        end
        if (dp_re) begin
            dp_rdata_reg <= dp_mem[dp_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        if (q_re) begin
            q_rdata_reg <= q_mem[head_reg[ID_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (pth_we) begin
            pth_mem[pth_waddr] <= cur_reg;
        end
        if (pth_re) begin
            pth_rdata_reg <= pth_mem[in_path_index];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
        end else if (adj_we) begin
            present_reg[in_node_id] <= in_node_present;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            stored_len_reg <= '0;
            clr_cnt_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            found_reg      <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        unique case (in_mode)
                            MODE_SOLVE: begin
                                stored_len_reg <= '0;
                                start_reg      <= in_start_node;
                                end_reg        <= in_end_node;
                                found_reg      <= 1'b0;
                                len_reg        <= '0;
                                clr_cnt_reg    <= '0;
                                if (present_reg[in_start_node] &&
                                    present_reg[in_end_node]) begin
                                    state_reg <= ST_CLEAR;
                                end else begin
                                    state_reg <= ST_FINISH;
                                end
                            end
                            MODE_READ: begin
                                ivalid_reg <= ({1'b0, in_path_index} < stored_len_reg);
                                state_reg  <= ST_RDPATH;
                            end
                            MODE_LOAD, MODE_NOP: begin
                                m_tvalid_reg <= 1'b1;
                                m_tdata_reg  <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RDPATH: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'd0, ivalid_reg,
                                         ivalid_reg ? pth_rdata_reg : {ID_W{1'b0}},
                                         stored_len_reg, stored_len_reg != '0};
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == (ID_W+1)'(NODES-1)) begin
                        state_reg <= ST_INIT;
                    end
                end
                ST_INIT: begin
                    head_reg  <= '0;
                    tail_reg  <= (ID_W+1)'(1);
                    state_reg <= ST_POP;
                end
                ST_POP: begin
                    if (head_reg == tail_reg) begin
                        state_reg <= ST_FINISH;     // queue drained, no path
                    end else begin
                        head_reg  <= head_reg + 1'b1;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    u_reg <= q_rdata_reg[ID_W-1:0];
                    d_reg <= q_rdata_reg[Q_W-1 -: DIST_W];
                    k_reg <= '0;
                    if (q_rdata_reg[ID_W-1:0] == end_reg) begin
                        // end taken: all its candidate parents are expanded
                        len_reg   <= q_rdata_reg[Q_W-1 -: DIST_W] + LEN_W'(1);
                        kidx_reg  <= q_rdata_reg[Q_W-2 -: ID_W];
                        cur_reg   <= end_reg;
                        state_reg <= ST_TRACE;
                    end else begin
                        state_reg <= ST_NB_RD;
                    end
                end
                ST_NB_RD: begin
                    if (nb_ok) begin
                        state_reg <= ST_NB_WR;
                    end else if (k_reg == 2'd3) begin
                        state_reg <= ST_POP;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_NB_WR: begin
                    if (nb_new) begin
                        tail_reg <= tail_reg + 1'b1;
                    end
                    if (k_reg == 2'd3) begin
                        state_reg <= ST_POP;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_NB_RD;
                    end
                end
                ST_TRACE: begin
                    if (cur_reg == start_reg) begin
                        found_reg      <= 1'b1;
                        stored_len_reg <= len_reg;
                        state_reg      <= ST_FINISH;
                    end else begin
                        kidx_reg  <= kidx_reg - 1'b1;
                        state_reg <= ST_TRACE_WAIT;
                    end
                end
                ST_TRACE_WAIT: begin
                    cur_reg   <= dp_rdata_reg[ID_W-1:0];
                    state_reg <= ST_TRACE;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'd0, 1'b0, {ID_W{1'b0}},
                                         found_reg ? len_reg : {LEN_W{1'b0}},
                                         found_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
